// ===== src/fls_pkg.sv =====
package fls_pkg;

   localparam int MAX_ENTRIES_DEF   = 64;
   localparam int VALUE_WIDTH_DEF   = 32;
   localparam int NUM_FIELD_WIDTH   = 32;
   localparam int DEN_FIELD_WIDTH   = 31;
   localparam int COUNT_FIELD_WIDTH = 7;

   typedef struct packed {
      logic signed [NUM_FIELD_WIDTH-1:0] numerator;
      logic signed [NUM_FIELD_WIDTH-1:0] denominator;
      logic                              last;
   } req_word_type;

   typedef struct packed {
      logic signed [NUM_FIELD_WIDTH-1:0] reduced_numerator;
      logic [DEN_FIELD_WIDTH-1:0]        reduced_denominator;
      logic                              is_minimum;
      logic [COUNT_FIELD_WIDTH-1:0]      minimum_count;
      logic                              dropped_flag;
      logic                              end_of_list;
   } rsp_word_type;

   typedef struct packed {
      logic last;
      logic zero_den;
      logic neg;
   } front_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_STORE,
      ST_POST,
      ST_RD,
      ST_WAIT,
      ST_CMP,
      ST_ADV,
      ST_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      PH_MIN,
      PH_CNT,
      PH_SEL
   } scan_phase_type;

endpackage

// ===== src/fls_ram.sv =====
module fls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fls_front.sv =====
module fls_front import fls_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_word_type           req_word,
   output logic                   q_valid,
   input  logic                   q_pop,
   output front_ctl_type          q_ctl,
   output logic [VALUE_WIDTH-1:0] q_num_mag,
   output logic [VALUE_WIDTH-1:0] q_den_mag
);

   localparam int QW = 3 + 2 * VALUE_WIDTH;

   logic [QW-1:0]          slot_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             fill_ff, fill_in;
   logic signed [VALUE_WIDTH-1:0] num_s, den_s;
   logic [VALUE_WIDTH-1:0] num_mag, den_mag;
   front_ctl_type          ctl;
   logic                   do_push;

   always_comb begin
      num_s        = req_word.numerator[VALUE_WIDTH-1:0];
      den_s        = req_word.denominator[VALUE_WIDTH-1:0];
      num_mag      = num_s[VALUE_WIDTH-1] ? (~num_s + 1'b1) : num_s;
      den_mag      = den_s[VALUE_WIDTH-1] ? (~den_s + 1'b1) : den_s;
      ctl.last     = req_word.last;
      ctl.zero_den = (den_s == '0);
      ctl.neg      = num_s[VALUE_WIDTH-1] ^ den_s[VALUE_WIDTH-1];
   end

   assign full    = (fill_ff == 2'd2);
   assign q_valid = (fill_ff != 2'd0);
   assign do_push = push && !full;
   assign {q_ctl, q_num_mag, q_den_mag} = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= {ctl, num_mag, den_mag};
      end
   end

endmodule

// ===== src/fls_back.sv =====
module fls_back import fls_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  front_ctl_type                 q_ctl,
   input  logic [VALUE_WIDTH-1:0]        q_num_mag,
   input  logic [VALUE_WIDTH-1:0]        q_den_mag,
   output logic                          ram_wr_en,
   output logic [$clog2(MAX_ENTRIES)-1:0] ram_wr_addr,
   output logic [2*VALUE_WIDTH-2:0]      ram_wr_data,
   output logic [$clog2(MAX_ENTRIES)-1:0] ram_rd_addr,
   input  logic [2*VALUE_WIDTH-2:0]      ram_rd_data,
   output logic                          empty,
   input  logic                          pop,
   output rsp_word_type                  rsp_word
);

   localparam int VW = VALUE_WIDTH;
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int KW = $clog2(VW);
   localparam int PW = 2 * VW;

   back_state_type  state_ff, state_in;
   scan_phase_type  phase_ff, phase_in;
   front_ctl_type   ctl_ff, ctl_in;
   logic [VW-1:0]   u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [VW-1:0]   qn_ff, qn_in, qd_ff, qd_in;
   logic [VW:0]     rem_n_ff, rem_n_in, rem_d_ff, rem_d_in;
   logic [KW-1:0]   bit_ff, bit_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            drop_ff, drop_in;
   logic [CW-1:0]   scan_ff, scan_in;
   logic [CW-1:0]   mincnt_ff, mincnt_in;
   logic [CW-1:0]   emitcnt_ff, emitcnt_in;
   logic signed [VW-1:0] ref_n_ff, ref_n_in;
   logic [VW-2:0]   ref_d_ff, ref_d_in;
   logic            have_ff, have_in;
   logic [AW-1:0]   best_ff, best_in;
   logic [MAX_ENTRIES-1:0] emitted_ff, emitted_in, ismin_ff, ismin_in;
   logic signed [PW-1:0] p1_ff, p1_in, p2_ff, p2_in;
   rsp_word_type    rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]   idx;
   logic signed [VW-1:0] ent_n;
   logic [VW-2:0]   ent_d;
   logic [VW:0]     sh_n, sh_d;
   logic            ge_n, ge_d;
   logic            neg_eff;
   logic [VW-1:0]   st_num;
   logic [VW-2:0]   st_den;
   logic            store_full, scan_last, emit_last, out_free, skip;
   logic            less, greater, equal;

   assign idx        = scan_ff[AW-1:0];
   assign ent_n      = ram_rd_data[2*VW-2:VW-1];
   assign ent_d      = ram_rd_data[VW-2:0];
   assign sh_n       = {rem_n_ff[VW-1:0], qn_ff[VW-1]};
   assign sh_d       = {rem_d_ff[VW-1:0], qd_ff[VW-1]};
   assign ge_n       = (sh_n >= {1'b0, g_ff});
   assign ge_d       = (sh_d >= {1'b0, g_ff});
   assign store_full = (count_ff == CW'(MAX_ENTRIES));
   assign scan_last  = (scan_ff == CW'(count_ff - 1'b1));
   assign emit_last  = (emitcnt_ff == CW'(count_ff - 1'b1));
   assign out_free   = !rsp_valid_ff || pop;
   assign skip       = (phase_ff == PH_SEL) && emitted_ff[idx];
   assign less       = (p1_ff < p2_ff);
   assign greater    = (p2_ff < p1_ff);
   assign equal      = (p1_ff == p2_ff);

   always_comb begin
      neg_eff = ctl_ff.neg && (qn_ff != '0);
      if (neg_eff) begin
         st_num = ~qn_ff + 1'b1;
      end else if (qn_ff[VW-1]) begin
         st_num = {1'b0, {(VW-1){1'b1}}};
      end else begin
         st_num = qn_ff;
      end
      st_den = qd_ff[VW-1] ? {(VW-1){1'b1}} : qd_ff[VW-2:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_ctl.zero_den || store_full) ? ST_POST : ST_GCD;
            end
         end
         ST_GCD: begin
            if (u_ff == '0) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (bit_ff == KW'(VW - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: state_in = ST_POST;
         ST_POST: begin
            if (ctl_ff.last && (count_ff != '0)) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD:   state_in = skip ? ST_ADV : ST_WAIT;
         ST_WAIT: state_in = ST_CMP;
         ST_CMP:  state_in = ST_ADV;
         ST_ADV: begin
            if (scan_last && (phase_ff == PH_SEL)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      ctl_in       = ctl_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      rem_n_in     = rem_n_ff;
      rem_d_in     = rem_d_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      scan_in      = scan_ff;
      mincnt_in    = mincnt_ff;
      emitcnt_in   = emitcnt_ff;
      ref_n_in     = ref_n_ff;
      ref_d_in     = ref_d_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      emitted_in   = emitted_ff;
      ismin_in     = ismin_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      q_pop        = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[AW-1:0];
      ram_wr_data  = {st_num, st_den};
      ram_rd_addr  = idx;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ctl_in = q_ctl;
               u_in   = q_num_mag;
               v_in   = q_den_mag;
               qn_in  = q_num_mag;
               qd_in  = q_den_mag;
               k_in   = '0;
               if (q_ctl.zero_den || store_full) begin
                  drop_in = 1'b1;
               end
            end
         end
         ST_GCD: begin
            if (u_ff == '0) begin
               g_in     = VW'(v_ff << k_ff);
               rem_n_in = '0;
               rem_d_in = '0;
               bit_in   = '0;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         ST_DIV: begin
            rem_n_in = ge_n ? (sh_n - {1'b0, g_ff}) : sh_n;
            rem_d_in = ge_d ? (sh_d - {1'b0, g_ff}) : sh_d;
            qn_in    = {qn_ff[VW-2:0], ge_n};
            qd_in    = {qd_ff[VW-2:0], ge_d};
            bit_in   = bit_ff + 1'b1;
         end
         ST_STORE: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + 1'b1;
         end
         ST_POST: begin
            phase_in   = PH_MIN;
            scan_in    = '0;
            mincnt_in  = '0;
            emitcnt_in = '0;
            emitted_in = '0;
            ismin_in   = '0;
            have_in    = 1'b0;
            if (ctl_ff.last && (count_ff == '0)) begin
               drop_in = 1'b0;
            end
         end
         ST_WAIT: begin
            p1_in = ent_n * signed'({1'b0, ref_d_ff});
            p2_in = ref_n_ff * signed'({1'b0, ent_d});
         end
         ST_CMP: begin
            case (phase_ff)
               PH_MIN: begin
                  if ((scan_ff == '0) || less) begin
                     ref_n_in = ent_n;
                     ref_d_in = ent_d;
                  end
               end
               PH_CNT: begin
                  if (equal) begin
                     mincnt_in     = mincnt_ff + 1'b1;
                     ismin_in[idx] = 1'b1;
                  end
               end
               PH_SEL: begin
                  if (!have_ff || greater) begin
                     ref_n_in = ent_n;
                     ref_d_in = ent_d;
                     best_in  = idx;
                     have_in  = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_ADV: begin
            if (scan_last) begin
               scan_in = '0;
               case (phase_ff)
                  PH_MIN:  phase_in = PH_CNT;
                  PH_CNT:  phase_in = PH_SEL;
                  default: phase_in = PH_SEL;
               endcase
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_in.reduced_numerator    = NUM_FIELD_WIDTH'(ref_n_ff);
               rsp_in.reduced_denominator  = DEN_FIELD_WIDTH'(ref_d_ff);
               rsp_in.is_minimum           = ismin_ff[best_ff];
               rsp_in.minimum_count        = COUNT_FIELD_WIDTH'(mincnt_ff);
               rsp_in.dropped_flag         = drop_ff;
               rsp_in.end_of_list          = emit_last;
               emitted_in[best_ff]         = 1'b1;
               emitcnt_in                  = emitcnt_ff + 1'b1;
               have_in                     = 1'b0;
               scan_in                     = '0;
               if (emit_last) begin
                  count_in = '0;
                  drop_in  = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_MIN;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         mincnt_ff    <= '0;
         emitcnt_ff   <= '0;
         have_ff      <= 1'b0;
         emitted_ff   <= '0;
         ismin_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         mincnt_ff    <= mincnt_in;
         emitcnt_ff   <= emitcnt_in;
         have_ff      <= have_in;
         emitted_ff   <= emitted_in;
         ismin_ff     <= ismin_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff   <= ctl_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      g_ff     <= g_in;
      k_ff     <= k_in;
      qn_ff    <= qn_in;
      qd_ff    <= qd_in;
      rem_n_ff <= rem_n_in;
      rem_d_ff <= rem_d_in;
      bit_ff   <= bit_in;
      ref_n_ff <= ref_n_in;
      ref_d_ff <= ref_d_in;
      best_ff  <= best_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      rsp_ff   <= rsp_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule

// ===== src/fraction_list_sorter_top.sv =====
// Storing a word runs the binary GCD of the numerator and denominator magnitudes, then
// divides both by it, one quotient bit per step, and writes the entry; a dropped word skips these steps.
// A last word then starts the sort if the list holds entries: two scans plus one scan per output word,
// each scan stepping through every stored entry (an entry already sent is not compared) via the single RAM
// read port and multiplier pair, with each output word sent once the output is free.
// Words may queue two deep in front while the back end works.
// Synchronous reset empties the list, the drop flag and both queues; the RAM is not cleared.
module fraction_list_sorter_top import fls_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int RW = 2 * VALUE_WIDTH - 1;

   logic                   q_valid, q_pop;
   front_ctl_type          q_ctl;
   logic [VALUE_WIDTH-1:0] q_num_mag, q_den_mag;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [RW-1:0]          ram_wr_data, ram_rd_data;

   fls_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_ctl     (q_ctl),
      .q_num_mag (q_num_mag),
      .q_den_mag (q_den_mag)
   );

   fls_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fls_back #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_ctl       (q_ctl),
      .q_num_mag   (q_num_mag),
      .q_den_mag   (q_den_mag),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_word    (rsp_word)
   );

endmodule
